// ===== rtl/core/jset_pkg.sv =====
`timescale 1ns / 1ps

package jset_pkg;

    // Fixed-point format and grid limits
    localparam int FRAC_BITS      = 28;
    localparam int MAX_DIM        = 4096;
    localparam int MAX_ITERATIONS = 1024;

    // Field and datapath widths
    localparam int IDX_W      = 13;                      // grid index and count
    localparam int DIV_W      = 12;                      // divisor and remainder
    localparam int NUM_W      = DIV_W + 2 + FRAC_BITS;   // numerator and quotient
    localparam int ITER_W     = 11;                      // iteration count
    localparam int COORD_W    = NUM_W + 2;               // signed start coordinate
    localparam int Z_W        = FRAC_BITS + 3;           // bounded iterate, |z| <= r < 4.0
    localparam int PROD_W     = 2 * Z_W;                 // exact product of two iterates
    localparam int NZ_W       = PROD_W - FRAC_BITS;      // next iterate before bound check
    localparam int RAD_W      = 30;                      // escape radius
    localparam int RR_W       = 2 * RAD_W;               // radius squared
    localparam int C_W        = 32;                      // Julia constant parts
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_C_REAL        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_RADIUS = 3'd5;

    // Configuration reset values
    localparam logic [IDX_W-1:0]  RST_ROW_COUNT     = IDX_W'(1024);
    localparam logic [IDX_W-1:0]  RST_COL_COUNT     = IDX_W'(1024);
    localparam logic [ITER_W-1:0] RST_MAX_ITER      = ITER_W'(64);
    localparam logic [RAD_W-1:0]  RST_ESCAPE_RADIUS = RAD_W'(1) << (FRAC_BITS + 1);

    // 1.5 in the start coordinate format
    localparam logic signed [COORD_W-1:0] HALF3 = COORD_W'(3) << (FRAC_BITS - 1);

    // One lane of the divider chain
    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
        logic [DIV_W-1:0] dvs;
    } t_div_lane;

    // One stage of the divider chain: real and imaginary lanes
    typedef struct packed {
        logic      valid;
        t_div_lane re;
        t_div_lane im;
    } t_div_stage;

    // Control from the sequencer to the iteration unit
    typedef struct packed {
        logic start;
        logic ack;
    } t_iter_ctl;

    // Status from the iteration unit
    typedef struct packed {
        logic done;
        logic in_set;
    } t_iter_sts;

    // One restoring division step: shift in the next numerator bit, subtract if it fits
    function automatic t_div_lane div_step(input t_div_lane l);
        t_div_lane        o;
        logic [DIV_W:0]   trial;
        logic             fit;
        trial = {l.rem, l.num[NUM_W-1]};
        fit   = (trial >= {1'b0, l.dvs});
        o     = l;
        o.num = {l.num[NUM_W-2:0], 1'b0};
        o.quo = {l.quo[NUM_W-2:0], fit};
        o.rem = fit ? DIV_W'(trial - {1'b0, l.dvs}) : trial[DIV_W-1:0];
        return o;
    endfunction

    // 3*(idx-1) scaled to FRAC_BITS fraction bits, index clamped to [1, MAX_DIM]
    function automatic logic [NUM_W-1:0] span_num(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0]   c;
        logic [DIV_W-1:0]   m;
        logic [DIV_W+1:0]   t3;
        if (idx == '0) begin
            c = IDX_W'(1);
        end else if (idx > IDX_W'(MAX_DIM)) begin
            c = IDX_W'(MAX_DIM);
        end else begin
            c = idx;
        end
        m  = DIV_W'(c - IDX_W'(1));
        t3 = {2'b00, m} + {1'b0, m, 1'b0};
        return {t3, {FRAC_BITS{1'b0}}};
    endfunction

    // count-1 with the count clamped to [2, MAX_DIM]
    function automatic logic [DIV_W-1:0] span_div(input logic [IDX_W-1:0] cnt);
        logic [IDX_W-1:0] c;
        if (cnt < IDX_W'(2)) begin
            c = IDX_W'(2);
        end else if (cnt > IDX_W'(MAX_DIM)) begin
            c = IDX_W'(MAX_DIM);
        end else begin
            c = cnt;
        end
        return DIV_W'(c - IDX_W'(1));
    endfunction

endpackage

// ===== rtl/core/jset_div_cell.sv =====
`timescale 1ns / 1ps

module jset_div_cell import jset_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_div_stage i_stage,
    output t_div_stage o_stage
);

    t_div_stage r_stage;
    t_div_stage n_stage;

    // Resolve one quotient bit in each lane
    always_comb begin
        n_stage.valid = i_stage.valid;
        n_stage.re    = div_step(i_stage.re);
        n_stage.im    = div_step(i_stage.im);
    end

    // Hand the partial result to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
        r_stage.re <= n_stage.re;
        r_stage.im <= n_stage.im;
    end

    assign o_stage = r_stage;

endmodule

// ===== rtl/core/jset_iter.sv =====
`timescale 1ns / 1ps

module jset_iter import jset_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_iter_ctl               i_ctl,
    input  logic [NUM_W-1:0]        i_quo_re,
    input  logic [NUM_W-1:0]        i_quo_im,
    input  logic [ITER_W-1:0]       i_steps,
    input  logic [RAD_W-1:0]        i_radius,
    input  logic [RR_W-1:0]         i_rr,
    input  logic signed [C_W-1:0]   i_c_real,
    input  logic signed [C_W-1:0]   i_c_imag,
    output t_iter_sts               o_sts
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ACC  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    logic signed [Z_W-1:0]      r_a, r_b, n_a, n_b;
    logic [ITER_W-1:0]          r_k, n_k;
    logic                       r_inside, n_inside;
    logic signed [PROD_W-1:0]   r_paa, r_pbb, r_pab;
    logic signed [COORD_W-1:0]  w_a0, w_b0, w_na_ext, w_nb_ext;
    logic signed [PROD_W-1:0]   w_diff;
    logic signed [NZ_W-1:0]     w_na, w_nb;
    logic [RR_W:0]              w_sum;
    logic                       w_in0, w_in_next;

    // |x| <= r
    function automatic logic mag_le(input logic signed [COORD_W-1:0] x,
                                    input logic [RAD_W-1:0] r);
        logic [COORD_W-1:0] m;
        m = x[COORD_W-1] ? -x : x;
        return m <= {{(COORD_W-RAD_W){1'b0}}, r};
    endfunction

    // Start point from the divider quotients
    assign w_a0  = $signed({2'b00, i_quo_re}) - HALF3;
    assign w_b0  = HALF3 - $signed({2'b00, i_quo_im});
    assign w_in0 = mag_le(w_a0, i_radius) && mag_le(w_b0, i_radius);

    // Magnitude of the current iterate, from its squares; one extra bit for the carry
    assign w_sum = {1'b0, r_paa[RR_W-1:0]} + {1'b0, r_pbb[RR_W-1:0]};

    // Next iterate: floor shift is a plain bit select, then add c
    assign w_diff    = r_paa - r_pbb;
    assign w_na      = $signed(w_diff[PROD_W-1:FRAC_BITS]) + NZ_W'(i_c_real);
    assign w_nb      = $signed(r_pab[FRAC_BITS+NZ_W-2:FRAC_BITS-1]) + NZ_W'(i_c_imag);
    assign w_na_ext  = COORD_W'(w_na);
    assign w_nb_ext  = COORD_W'(w_nb);
    assign w_in_next = mag_le(w_na_ext, i_radius) && mag_le(w_nb_ext, i_radius);

    // Step sequencer
    always_comb begin
        n_state  = r_state;
        n_a      = r_a;
        n_b      = r_b;
        n_k      = r_k;
        n_inside = r_inside;
        unique case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    if (w_in0) begin
                        n_a     = w_a0[Z_W-1:0];
                        n_b     = w_b0[Z_W-1:0];
                        n_k     = '0;
                        n_state = S_MUL;
                    end else begin
                        n_inside = 1'b0;
                        n_state  = S_DONE;
                    end
                end
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                priority if (w_sum > {1'b0, i_rr}) begin
                    n_inside = 1'b0;
                    n_state  = S_DONE;
                end else if (r_k == i_steps) begin
                    n_inside = 1'b1;
                    n_state  = S_DONE;
                end else if (!w_in_next) begin
                    n_inside = 1'b0;
                    n_state  = S_DONE;
                end else begin
                    n_a     = w_na[Z_W-1:0];
                    n_b     = w_nb[Z_W-1:0];
                    n_k     = r_k + ITER_W'(1);
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                if (i_ctl.ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state; form the three products every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_a      <= n_a;
        r_b      <= n_b;
        r_k      <= n_k;
        r_inside <= n_inside;
        r_paa    <= r_a * r_a;
        r_pbb    <= r_b * r_b;
        r_pab    <= r_a * r_b;
    end

    assign o_sts.done   = (r_state == S_DONE);
    assign o_sts.in_set = r_inside;

endmodule

// ===== rtl/core/julia_set_point_test.sv =====
`timescale 1ns / 1ps

// Julia set escape-time test for one grid point per transaction. The point's
// 1-based column and row are turned into a start value by a chain of 42
// restoring-divider cells (both axes side by side), then a shared complex
// multiply unit iterates z = z*z + c in Q3.28, each iteration being a product
// register step, then subtract/shift/add and escape check. One point is
// worked on at a time, and the next point is taken as soon as the result sits
// in the output register.
// The output is 1 when the point never left the escape radius.

module julia_set_point_test import jset_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [IDX_W-1:0]       i_col,
    input  logic [IDX_W-1:0]       i_row,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_inside_res,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_ITER = 3'b100
    } t_state;

    t_state                    r_state, n_state;
    logic [IDX_W-1:0]          r_row_count, r_col_count;
    logic [ITER_W-1:0]         r_max_iter;
    logic signed [C_W-1:0]     r_c_real, r_c_imag;
    logic [RAD_W-1:0]          r_escape_radius;
    logic [RR_W-1:0]           r_rr;
    logic                      r_out_valid, n_out_valid;
    logic                      r_out_res, n_out_res;
    logic [ITER_W-1:0]         w_steps;
    logic                      w_in_accept, w_cfg_write, w_load;
    t_div_stage                w_link [NUM_W+1];
    logic [NUM_W-1:0]          w_chain_valid;
    t_iter_ctl                 w_ctl;
    t_iter_sts                 w_sts;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count     <= RST_ROW_COUNT;
            r_col_count     <= RST_COL_COUNT;
            r_max_iter      <= RST_MAX_ITER;
            r_c_real        <= '0;
            r_c_imag        <= '0;
            r_escape_radius <= RST_ESCAPE_RADIUS;
        end else if (w_cfg_write) begin
            unique case (i_cfg_index)
                CFG_ROW_COUNT:     r_row_count     <= i_cfg_data[IDX_W-1:0];
                CFG_COL_COUNT:     r_col_count     <= i_cfg_data[IDX_W-1:0];
                CFG_MAX_ITER:      r_max_iter      <= i_cfg_data[ITER_W-1:0];
                CFG_C_REAL:        r_c_real        <= $signed(i_cfg_data[C_W-1:0]);
                CFG_C_IMAG:        r_c_imag        <= $signed(i_cfg_data[C_W-1:0]);
                CFG_ESCAPE_RADIUS: r_escape_radius <= i_cfg_data[RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Radius squared, settled long before the first magnitude check
    always_ff @(posedge i_clk) begin
        r_rr <= r_escape_radius * r_escape_radius;
    end

    assign w_steps = (r_max_iter > ITER_W'(MAX_ITERATIONS)) ? ITER_W'(MAX_ITERATIONS)
                                                             : r_max_iter;

    // Load both coordinate divisions into the head of the chain
    always_comb begin
        w_link[0].valid  = w_in_accept;
        w_link[0].re.rem = '0;
        w_link[0].re.num = span_num(i_col);
        w_link[0].re.quo = '0;
        w_link[0].re.dvs = span_div(r_col_count);
        w_link[0].im.rem = '0;
        w_link[0].im.num = span_num(i_row);
        w_link[0].im.quo = '0;
        w_link[0].im.dvs = span_div(r_row_count);
    end

    // Divider chain, one quotient bit per cell
    for (genvar g = 0; g < NUM_W; g++) begin : g_cell
        jset_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_link[g]),
            .o_stage (w_link[g+1])
        );
        assign w_chain_valid[g] = w_link[g+1].valid;
    end

    // Iteration unit
    assign w_ctl.start = w_link[NUM_W].valid;
    assign w_ctl.ack   = w_load;

    jset_iter u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_quo_re (w_link[NUM_W].re.quo),
        .i_quo_im (w_link[NUM_W].im.quo),
        .i_steps  (w_steps),
        .i_radius (r_escape_radius),
        .i_rr     (r_rr),
        .i_c_real (r_c_real),
        .i_c_imag (r_c_imag),
        .o_sts    (w_sts)
    );

    // Move a finished result into the output register when it is free
    assign w_load = (r_state == ST_ITER) && w_sts.done && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out_res   = r_out_res;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_link[NUM_W].valid) begin
                    n_state = ST_ITER;
                end
            end
            ST_ITER: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_res   = w_sts.in_set;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_out_res <= n_out_res;
    end

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_out_res;

    // At most one point travels down the divider chain
    a_chain_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_chain_valid) <= 1)
        else $error("more than one point in the divider chain");

    // Chain output arrives only while the sequencer waits for it
    a_chain_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[NUM_W].valid |-> r_state == ST_DIV)
        else $error("divider result outside the divide phase");

    // The iteration unit finishes only for the point in progress
    a_iter_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> r_state == ST_ITER)
        else $error("iteration result with no point in progress");

endmodule

// ===== tb/sv/julia_set_point_test_tb.sv =====
`timescale 1ns / 1ps

module julia_set_point_test_tb;
    import jset_pkg::*;

    localparam int CYCLE_LIMIT   = 6_000_000;
    localparam int RANDOM_POINTS = 560;
    localparam int IDLE_PCT      = 38;
    localparam int DRAIN_CYCLES  = 2 * MAX_ITERATIONS + 100;
    localparam int MAX_REPORTS   = 10;

    // Register indexes past the end of the map; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Tracks the register copy and the escape prediction of every accepted point
    class inside_scoreboard;
        logic [IDX_W-1:0]      rows;
        logic [IDX_W-1:0]      cols;
        logic [ITER_W-1:0]     iters;
        logic signed [C_W-1:0] c_re;
        logic signed [C_W-1:0] c_im;
        logic [RAD_W-1:0]      radius;
        bit                    inside_q[$];
        int                    errors;
        int                    checked;
        int                    inside_seen;

        function new();
            rows        = RST_ROW_COUNT;
            cols        = RST_COL_COUNT;
            iters       = RST_MAX_ITER;
            c_re        = '0;
            c_im        = '0;
            radius      = RST_ESCAPE_RADIUS;
            errors      = 0;
            checked     = 0;
            inside_seen = 0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ROW_COUNT:     rows   = data[IDX_W-1:0];
                CFG_COL_COUNT:     cols   = data[IDX_W-1:0];
                CFG_MAX_ITER:      iters  = data[ITER_W-1:0];
                CFG_C_REAL:        c_re   = data[C_W-1:0];
                CFG_C_IMAG:        c_im   = data[C_W-1:0];
                CFG_ESCAPE_RADIUS: radius = data[RAD_W-1:0];
                default: ;
            endcase
        endfunction

        // Truncated 3*(idx-1)/(count-1) with FRAC_BITS fraction bits
        function longint grid_offset(input logic [IDX_W-1:0] idx,
                                     input logic [IDX_W-1:0] cnt);
            longint unsigned k;
            longint unsigned d;
            longint unsigned three;
            three = longint'(3) << FRAC_BITS;
            k = (idx == '0) ? 1 : ((idx > MAX_DIM) ? MAX_DIM : idx);
            d = (cnt < 2) ? 2 : ((cnt > MAX_DIM) ? MAX_DIM : cnt);
            return longint'(((k - 1) * three) / (d - 1));
        endfunction

        // Each part bounded by r first, then the exact squared magnitude
        function bit in_radius(input longint a, input longint b, input longint r);
            longint ma;
            longint mb;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            if (ma > r || mb > r) begin
                return 1'b0;
            end
            return (a * a + b * b) <= (r * r);
        endfunction

        function bit predict_inside(input logic [IDX_W-1:0] col,
                                    input logic [IDX_W-1:0] row);
            longint half3;
            longint a;
            longint b;
            longint r;
            longint na;
            longint nb;
            int     steps;
            int     k;
            half3 = longint'(3) << (FRAC_BITS - 1);
            a     = grid_offset(col, cols) - half3;
            b     = half3 - grid_offset(row, rows);
            r     = longint'(radius);
            steps = (iters > MAX_ITERATIONS) ? MAX_ITERATIONS : int'(iters);
            if (!in_radius(a, b, r)) begin
                return 1'b0;
            end
            for (k = 0; k < steps; k++) begin
                na = ((a * a - b * b) >>> FRAC_BITS) + longint'(c_re);
                nb = ((2 * a * b) >>> FRAC_BITS) + longint'(c_im);
                a  = na;
                b  = nb;
                if (!in_radius(a, b, r)) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void note_point(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
            inside_q = {inside_q, predict_inside(col, row)};
        endfunction

        function void check_result(input logic got);
            bit want;
            if (inside_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected result inside=%0b with no point outstanding", got);
                end
                return;
            end
            want = inside_q.pop_front();
            checked++;
            if (want) begin
                inside_seen++;
            end
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("result %0d: expected inside=%0b, got %0b", checked, want, got);
                end
            end
        endfunction

        function int pending();
            return inside_q.size();
        endfunction

        // Count every point that never got its result
        function void close_out();
            if (inside_q.size() != 0) begin
                $display("%0d points still waiting for a result", inside_q.size());
            end
            errors += inside_q.size();
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic [IDX_W-1:0]      i_col       = '0;
    logic [IDX_W-1:0]      i_row       = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_inside_res;
    logic                  o_cfg_ready;

    inside_scoreboard sb = new();
    int               idle_pct    = IDLE_PCT;
    int               stall_pct   = IDLE_PCT;
    int               cycle_count = 0;
    int               settings    = 0;

    julia_set_point_test uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_col        (i_col),
        .i_row        (i_row),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_inside_res (o_inside_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Guard against a hung block
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Check each result transaction, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_inside_res);
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Hold one config transaction until the block takes it; valid stays high
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(idx, data);
    endtask

    // Write all six registers, with junk above the width of the narrower fields
    task automatic program_all(input logic [IDX_W-1:0] rows, input logic [IDX_W-1:0] cols,
                               input logic [ITER_W-1:0] iters, input logic [C_W-1:0] c_re,
                               input logic [C_W-1:0] c_im, input logic [RAD_W-1:0] radius);
        cfg_write(CFG_ROW_COUNT, {19'($urandom()), rows});
        cfg_write(CFG_COL_COUNT, {19'($urandom()), cols});
        cfg_write(CFG_MAX_ITER, {21'($urandom()), iters});
        cfg_write(CFG_C_REAL, c_re);
        cfg_write(CFG_C_IMAG, c_im);
        cfg_write(CFG_ESCAPE_RADIUS, {2'($urandom()), radius});
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    // Offer one point after a random gap and wait for the input transaction
    task automatic send_point(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_col      <= col;
        i_row      <= row;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_point(col, row);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic finish_phase();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [C_W-1:0] to_fixed(input real v);
        return C_W'($rtoi(v * (2.0 ** FRAC_BITS)));
    endfunction

    // Mostly small grids, some large, a few out of the legal range
    function automatic logic [IDX_W-1:0] pick_count();
        case ($urandom_range(9))
            0:       return IDX_W'($urandom_range(0, 8191));
            1:       return IDX_W'($urandom_range(41, MAX_DIM));
            default: return IDX_W'($urandom_range(2, 40));
        endcase
    endfunction

    // Mostly on the grid, some at the edges, some anywhere in the field
    function automatic logic [IDX_W-1:0] pick_index(input logic [IDX_W-1:0] cnt);
        int unsigned lim;
        lim = (cnt < 2) ? 2 : ((cnt > MAX_DIM) ? MAX_DIM : cnt);
        case ($urandom_range(9))
            0: return IDX_W'($urandom_range(0, 8191));
            1: begin
                case ($urandom_range(4))
                    0:       return '0;
                    1:       return IDX_W'(1);
                    2:       return IDX_W'(lim);
                    3:       return IDX_W'(MAX_DIM);
                    default: return '1;
                endcase
            end
            default: return IDX_W'($urandom_range(1, lim));
        endcase
    endfunction

    // Random register setting; a long run keeps c at zero so points survive
    task automatic random_config(input bit long_run);
        logic [ITER_W-1:0] iters;
        logic [C_W-1:0]    c_re;
        logic [C_W-1:0]    c_im;
        logic [RAD_W-1:0]  radius;
        if (long_run) begin
            iters = $urandom_range(1) ? ITER_W'(MAX_ITERATIONS) : ITER_W'($urandom_range(1025, 2047));
        end else if ($urandom_range(9) == 0) begin
            iters = ITER_W'($urandom_range(0, 4));
        end else begin
            iters = ITER_W'($urandom_range(5, 48));
        end
        case (long_run ? 0 : $urandom_range(8))
            0: begin
                c_re = '0;
                c_im = '0;
            end
            1: begin
                c_re = to_fixed(-0.4);
                c_im = to_fixed(0.6);
            end
            2: begin
                c_re = to_fixed(-0.8);
                c_im = to_fixed(0.156);
            end
            3: begin
                c_re = to_fixed(0.285);
                c_im = to_fixed(0.01);
            end
            4: begin
                c_re = to_fixed(-0.7269);
                c_im = to_fixed(0.1889);
            end
            8: begin
                c_re = $urandom();
                c_im = $urandom();
            end
            default: begin
                c_re = C_W'(int'($urandom_range(0, 483183820)) - 241591910);
                c_im = C_W'(int'($urandom_range(0, 483183820)) - 241591910);
            end
        endcase
        case ($urandom_range(9))
            0:       radius = RAD_W'($urandom_range(0, (1 << 30) - 1));
            1, 2:    radius = RAD_W'($urandom_range(0, 1 << 29));
            default: radius = RST_ESCAPE_RADIUS;
        endcase
        program_all(pick_count(), pick_count(), iters, c_re, c_im, radius);
    endtask

    initial begin
        int sent;
        int n;
        int k;
        int phase;
        sent  = 0;
        phase = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: corners, center, index zero and indexes past the grid
        send_point(13'd1, 13'd1);
        send_point(13'd1024, 13'd1024);
        send_point(13'd512, 13'd512);
        send_point(13'd513, 13'd513);
        send_point(13'd0, 13'd0);
        send_point(13'd4096, 13'd4096);
        send_point(13'd8191, 13'd8191);
        send_point(13'd0, 13'd8191);
        send_point(13'd700, 13'd300);
        finish_phase();

        // Smallest grid; writes to unmapped indexes must leave the registers alone
        cfg_write(CFG_SPARE_LO, $urandom());
        cfg_write(CFG_SPARE_HI, $urandom());
        program_all(13'd2, 13'd2, 11'd64, '0, '0, RST_ESCAPE_RADIUS);
        send_point(13'd1, 13'd1);
        send_point(13'd2, 13'd2);
        send_point(13'd1, 13'd2);
        send_point(13'd3, 13'd3);
        finish_phase();

        // Counts below two raise the divisor to one
        program_all(13'd1, 13'd0, 11'd64, '0, '0, RST_ESCAPE_RADIUS);
        send_point(13'd1, 13'd1);
        send_point(13'd2, 13'd1);
        finish_phase();

        // Counts above the largest grid clamp; no iterations at all
        program_all(13'd8191, 13'd4097, 11'd0, to_fixed(-0.4), to_fixed(0.6), RST_ESCAPE_RADIUS);
        send_point(13'd2048, 13'd2048);
        send_point(13'd4096, 13'd1);
        finish_phase();

        // Zero radius: only the origin survives, through the full iteration count
        program_all(13'd3, 13'd3, ITER_W'(MAX_ITERATIONS), '0, '0, '0);
        send_point(13'd2, 13'd2);
        send_point(13'd1, 13'd1);
        finish_phase();

        // Extreme c with the widest radius and an over-range iteration count
        program_all(13'd3, 13'd3, 11'd2047, 32'h8000_0000, 32'h7FFF_FFFF, '1);
        send_point(13'd2, 13'd2);
        finish_phase();

        // Random settings; one long-iteration phase and one stretch with no idling
        while (sent < RANDOM_POINTS) begin
            random_config(phase == 2);
            n = (phase == 2) ? 6 : ((phase == 4) ? 70 : $urandom_range(20, 50));
            if (phase == 4) begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            for (k = 0; k < n && sent < RANDOM_POINTS; k++) begin
                send_point(pick_index(sb.cols), pick_index(sb.rows));
                sent++;
            end
            finish_phase();
            idle_pct  = IDLE_PCT;
            stall_pct = IDLE_PCT;
            phase++;
        end

        // Let any stray result show up before closing
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.close_out();
        $display("checked %0d grid points across %0d register settings",
                 sb.checked, settings);
        $display("%0d points stayed bounded, %0d escaped, %0d errors",
                 sb.inside_seen, sb.checked - sb.inside_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
